[src/swst_pkg.sv]
// ----------------------------------------------------------------------------
// swst_pkg
// Shared sizes, codes and types for the SAP wildcard socket table.
// ----------------------------------------------------------------------------
package swst_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = 1;
   localparam int Q_CNT_W     = 2;

   localparam int ID_W  = 16;
   localparam int SAP_W = 9;
   localparam int FSAP_W = 8;

   localparam logic [SAP_W-1:0] SAP_ANY = 9'h1FF;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [1:0] RSP_OK   = 2'd0;
   localparam logic [1:0] RSP_MISS = 2'd1;
   localparam logic [1:0] RSP_FULL = 2'd2;

   typedef enum logic [1:0] {
      OP_CREATE,
      OP_DELETE,
      OP_LOOKUP,
      OP_EMPTY
   } swst_kind_type;

   typedef struct packed {
      swst_kind_type     kind;
      logic [ID_W-1:0]   id;
      logic [SAP_W-1:0]  lsap;
      logic [SAP_W-1:0]  rsap;
      logic [FSAP_W-1:0] dsap;
      logic [FSAP_W-1:0] ssap;
   } swst_op_type;

endpackage

[src/sap_wildcard_socket_table_core.sv]
// ----------------------------------------------------------------------------
// sap_wildcard_socket_table_core
// Socket table with wildcard SAP matching: create, delete and frame lookup.
// ----------------------------------------------------------------------------
// A create, delete or empty lookup is stored in the queue and then answered from
// the response register, with no scan. A lookup with matches loads a match mask;
// the table scan then gives one result per cycle while the output is not stalled.
// A two-item queue decouples intake from the back-end execution unit.
// Reset empties the table and the queue at once; no clearing pass.
module sap_wildcard_socket_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [swst_pkg::ID_W-1:0]    req_socket_id,
   input  logic signed [swst_pkg::SAP_W-1:0] req_local_sap,
   input  logic signed [swst_pkg::SAP_W-1:0] req_remote_sap,
   input  logic                         req_tag_present,
   input  logic [swst_pkg::FSAP_W-1:0]  req_frame_dsap,
   input  logic [swst_pkg::FSAP_W-1:0]  req_frame_ssap,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_match_valid,
   output logic [swst_pkg::ID_W-1:0]    rsp_match_id,
   output logic                         rsp_last
);
   import swst_pkg::*;

   logic        q_valid;
   swst_op_type q_item;
   logic        q_pop;

   swst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_socket_id   (req_socket_id),
      .req_local_sap   (req_local_sap),
      .req_remote_sap  (req_remote_sap),
      .req_tag_present (req_tag_present),
      .req_frame_dsap  (req_frame_dsap),
      .req_frame_ssap  (req_frame_ssap),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   swst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_valid (rsp_match_valid),
      .rsp_match_id    (rsp_match_id),
      .rsp_last        (rsp_last)
   );

endmodule

[src/swst_front.sv]
// ----------------------------------------------------------------------------
// swst_front
// Accepts request items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module swst_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [swst_pkg::ID_W-1:0]    req_socket_id,
   input  logic signed [swst_pkg::SAP_W-1:0] req_local_sap,
   input  logic signed [swst_pkg::SAP_W-1:0] req_remote_sap,
   input  logic                         req_tag_present,
   input  logic [swst_pkg::FSAP_W-1:0]  req_frame_dsap,
   input  logic [swst_pkg::FSAP_W-1:0]  req_frame_ssap,
   output logic                         q_valid,
   output swst_pkg::swst_op_type        q_item,
   input  logic                         q_pop
);
   import swst_pkg::*;

   swst_op_type          queue_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;
   swst_op_type          op_in;
   logic                 push;

   assign req_stall = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      op_in.id   = req_socket_id;
      op_in.lsap = req_local_sap;
      op_in.rsap = req_remote_sap;
      op_in.dsap = req_frame_dsap;
      op_in.ssap = req_frame_ssap;
      if (req_cmd == CMD_CREATE) begin
         op_in.kind = OP_CREATE;
      end else if (req_cmd == CMD_DELETE) begin
         op_in.kind = OP_DELETE;
      end else if (req_cmd == CMD_LOOKUP && req_tag_present) begin
         op_in.kind = OP_LOOKUP;
      end else begin
         // untagged lookup or unused command: one empty answer
         op_in.kind = OP_EMPTY;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

[src/swst_back.sv]
// ----------------------------------------------------------------------------
// swst_back
// Holds the socket table sorted by id and carries out queued items.
// ----------------------------------------------------------------------------
module swst_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  swst_pkg::swst_op_type        q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_match_valid,
   output logic [swst_pkg::ID_W-1:0]    rsp_match_id,
   output logic                         rsp_last
);
   import swst_pkg::*;

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type              state_ff, state_in;
   logic [TABLE_SIZE-1:0]  valid_ff, valid_in;
   logic [ID_W-1:0]        id_ff     [TABLE_SIZE];
   logic [ID_W-1:0]        id_in     [TABLE_SIZE];
   logic [SAP_W-1:0]       local_ff  [TABLE_SIZE];
   logic [SAP_W-1:0]       local_in  [TABLE_SIZE];
   logic [SAP_W-1:0]       remote_ff [TABLE_SIZE];
   logic [SAP_W-1:0]       remote_in [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]  mask_ff, mask_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_match_valid_ff, rsp_match_valid_in;
   logic [ID_W-1:0]        rsp_match_id_ff, rsp_match_id_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [TABLE_SIZE-1:0]  id_hit;
   logic [TABLE_SIZE-1:0]  id_lt;
   logic [TABLE_SIZE-1:0]  del_ge;
   logic [TABLE_SIZE-1:0]  sap_mask;
   logic [TABLE_SIZE-1:0]  scan_onehot;
   logic [IDX_W-1:0]       scan_idx;
   logic                   out_free;

   logic [ID_W-1:0]        ins_id     [TABLE_SIZE];
   logic [SAP_W-1:0]       ins_local  [TABLE_SIZE];
   logic [SAP_W-1:0]       ins_remote [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]  ins_valid;
   logic [ID_W-1:0]        del_id     [TABLE_SIZE];
   logic [SAP_W-1:0]       del_local  [TABLE_SIZE];
   logic [SAP_W-1:0]       del_remote [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]  del_valid;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_valid = rsp_match_valid_ff;
   assign rsp_match_id    = rsp_match_id_ff;
   assign rsp_last        = rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // per-entry compares; valid entries form a prefix sorted by ascending id
   always_comb begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         id_hit[i]   = valid_ff[i] && (id_ff[i] == q_item.id);
         id_lt[i]    = valid_ff[i] && (id_ff[i] < q_item.id);
         sap_mask[i] = valid_ff[i]
                       && (local_ff[i] == SAP_ANY || local_ff[i] == {1'b0, q_item.dsap})
                       && (remote_ff[i] == SAP_ANY || remote_ff[i] == {1'b0, q_item.ssap});
      end
   end

   // insert in place: entries at or above the new id move up one slot
   always_comb begin
      ins_id[0]     = id_lt[0] ? id_ff[0] : q_item.id;
      ins_local[0]  = id_lt[0] ? local_ff[0] : q_item.lsap;
      ins_remote[0] = id_lt[0] ? remote_ff[0] : q_item.rsap;
      ins_valid[0]  = 1'b1;
      for (int i = 1; i < TABLE_SIZE; i++) begin
         if (id_lt[i]) begin
            ins_id[i]     = id_ff[i];
            ins_local[i]  = local_ff[i];
            ins_remote[i] = remote_ff[i];
         end else if (id_lt[i-1]) begin
            ins_id[i]     = q_item.id;
            ins_local[i]  = q_item.lsap;
            ins_remote[i] = q_item.rsap;
         end else begin
            ins_id[i]     = id_ff[i-1];
            ins_local[i]  = local_ff[i-1];
            ins_remote[i] = remote_ff[i-1];
         end
         ins_valid[i] = valid_ff[i-1];
      end
   end

   // delete: close the gap by moving later entries down one slot
   always_comb begin
      del_ge[0] = id_hit[0];
      for (int i = 1; i < TABLE_SIZE; i++) begin
         del_ge[i] = del_ge[i-1] | id_hit[i];
      end
      for (int i = 0; i < TABLE_SIZE - 1; i++) begin
         del_id[i]     = del_ge[i] ? id_ff[i+1] : id_ff[i];
         del_local[i]  = del_ge[i] ? local_ff[i+1] : local_ff[i];
         del_remote[i] = del_ge[i] ? remote_ff[i+1] : remote_ff[i];
         del_valid[i]  = del_ge[i] ? valid_ff[i+1] : valid_ff[i];
      end
      del_id[TABLE_SIZE-1]     = id_ff[TABLE_SIZE-1];
      del_local[TABLE_SIZE-1]  = local_ff[TABLE_SIZE-1];
      del_remote[TABLE_SIZE-1] = remote_ff[TABLE_SIZE-1];
      del_valid[TABLE_SIZE-1]  = del_ge[TABLE_SIZE-1] ? 1'b0 : valid_ff[TABLE_SIZE-1];
   end

   // lowest pending match is the next id in ascending order
   always_comb begin
      scan_idx = '0;
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            scan_idx = IDX_W'(i);
         end
      end
      scan_onehot = mask_ff & (~mask_ff + 1'b1);
   end

   always_comb begin
      state_in           = state_ff;
      valid_in           = valid_ff;
      id_in              = id_ff;
      local_in           = local_ff;
      remote_in          = remote_ff;
      mask_in            = mask_ff;
      q_pop              = 1'b0;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_match_valid_in = rsp_match_valid_ff;
      rsp_match_id_in    = rsp_match_id_ff;
      rsp_last_in        = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_item.kind == OP_LOOKUP && sap_mask != '0) begin
                  mask_in  = sap_mask;
                  state_in = S_SCAN;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_status_in      = RSP_OK;
                  rsp_match_valid_in = 1'b0;
                  rsp_match_id_in    = '0;
                  rsp_last_in        = 1'b1;
                  unique case (q_item.kind)
                     OP_CREATE: begin
                        if (id_hit != '0) begin
                           rsp_status_in = RSP_MISS;
                        end else if (valid_ff[TABLE_SIZE-1]) begin
                           rsp_status_in = RSP_FULL;
                        end else begin
                           valid_in  = ins_valid;
                           id_in     = ins_id;
                           local_in  = ins_local;
                           remote_in = ins_remote;
                        end
                     end
                     OP_DELETE: begin
                        if (id_hit == '0) begin
                           rsp_status_in = RSP_MISS;
                        end else begin
                           valid_in  = del_valid;
                           id_in     = del_id;
                           local_in  = del_local;
                           remote_in = del_remote;
                        end
                     end
                     OP_LOOKUP, OP_EMPTY: begin
                        // no match or no tag: keep the empty answer
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            if (out_free) begin
               mask_in            = mask_ff & ~scan_onehot;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = RSP_OK;
               rsp_match_valid_in = 1'b1;
               rsp_match_id_in    = id_ff[scan_idx];
               rsp_last_in        = (mask_in == '0);
               if (mask_in == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff              <= id_in;
      local_ff           <= local_in;
      remote_ff          <= remote_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_match_valid_ff <= rsp_match_valid_in;
      rsp_match_id_ff    <= rsp_match_id_in;
      rsp_last_ff        <= rsp_last_in;
   end

endmodule

[tb/tb_sap_wildcard_socket_table_core.sv]
// ----------------------------------------------------------------------------
// tb_sap_wildcard_socket_table_core
// Self-checking bench for the SAP wildcard socket table. A behavioral copy of
// the table predicts the answer to every accepted create, delete and lookup;
// a monitor compares each answer with the oldest prediction. Directed items
// cover wildcards, odd SAP codes, duplicates, misses and a full table, then
// random traffic runs under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_sap_wildcard_socket_table_core;
   import swst_pkg::*;

   localparam logic [1:0] CMD_NONE    = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         SETTLE      = 20;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ID_W-1:0]   id;
      logic [SAP_W-1:0]  lsap;
      logic [SAP_W-1:0]  rsap;
      logic              tag;
      logic [FSAP_W-1:0] dsap;
      logic [FSAP_W-1:0] ssap;
   } sock_cmd_type;

   typedef struct packed {
      logic [1:0]      status;
      logic            hit;
      logic [ID_W-1:0] hit_id;
      logic            last;
   } sock_answer_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_cmd = '0;
   logic [ID_W-1:0]          req_socket_id = '0;
   logic signed [SAP_W-1:0]  req_local_sap = '0;
   logic signed [SAP_W-1:0]  req_remote_sap = '0;
   logic                     req_tag_present = 1'b0;
   logic [FSAP_W-1:0]        req_frame_dsap = '0;
   logic [FSAP_W-1:0]        req_frame_ssap = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic                     rsp_match_valid;
   logic [ID_W-1:0]          rsp_match_id;
   logic                     rsp_last;

   // behavioral copy of the socket table
   logic                 tbl_valid [TABLE_SIZE];
   logic [ID_W-1:0]      tbl_id    [TABLE_SIZE];
   logic [SAP_W-1:0]     tbl_lsap  [TABLE_SIZE];
   logic [SAP_W-1:0]     tbl_rsap  [TABLE_SIZE];

   sock_answer_type pending_answers [$];
   int           mismatches  = 0;
   int           cycle_count = 0;
   int           idle_pct    = 0;
   int           stall_pct   = 0;

   sap_wildcard_socket_table_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_socket_id   (req_socket_id),
      .req_local_sap   (req_local_sap),
      .req_remote_sap  (req_remote_sap),
      .req_tag_present (req_tag_present),
      .req_frame_dsap  (req_frame_dsap),
      .req_frame_ssap  (req_frame_ssap),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_valid (rsp_match_valid),
      .rsp_match_id    (rsp_match_id),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   function automatic bit sap_hit(input logic [SAP_W-1:0] stored,
                                  input logic [FSAP_W-1:0] frame);
      return stored == SAP_ANY || stored == {1'b0, frame};
   endfunction

   function automatic void queue_answer(input sock_answer_type a);
      pending_answers.insert(pending_answers.size(), a);
   endfunction

   function automatic void queue_ack(input logic [1:0] status);
      queue_answer('{status, 1'b0, '0, 1'b1});
   endfunction

   // Apply one command to the table copy and queue the answers it causes.
   function automatic void predict_table_op(input sock_cmd_type c);
      int               slot;
      int               free_slot;
      int               pick;
      logic [ID_W:0]    floor_id;
      logic [ID_W-1:0]  hits [$];
      slot      = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (tbl_valid[i] && tbl_id[i] == c.id && slot < 0) slot = i;
         if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      end
      case (c.cmd)
         CMD_CREATE: begin
            if (slot >= 0) begin
               queue_ack(RSP_MISS);
            end else if (free_slot < 0) begin
               queue_ack(RSP_FULL);
            end else begin
               tbl_valid[free_slot] = 1'b1;
               tbl_id[free_slot]    = c.id;
               tbl_lsap[free_slot]  = c.lsap;
               tbl_rsap[free_slot]  = c.rsap;
               queue_ack(RSP_OK);
            end
         end
         CMD_DELETE: begin
            if (slot < 0) begin
               queue_ack(RSP_MISS);
            end else begin
               tbl_valid[slot] = 1'b0;
               queue_ack(RSP_OK);
            end
         end
         CMD_LOOKUP: begin
            // take the smallest matching id above the previous one each pass
            floor_id = '0;
            if (c.tag) begin
               do begin
                  pick = -1;
                  for (int i = 0; i < TABLE_SIZE; i++) begin
                     if (tbl_valid[i] && sap_hit(tbl_lsap[i], c.dsap) &&
                         sap_hit(tbl_rsap[i], c.ssap) && {1'b0, tbl_id[i]} >= floor_id &&
                         (pick < 0 || tbl_id[i] < tbl_id[pick]))
                        pick = i;
                  end
                  if (pick >= 0) begin
                     hits.insert(hits.size(), tbl_id[pick]);
                     floor_id = {1'b0, tbl_id[pick]} + 1'b1;
                  end
               end while (pick >= 0);
            end
            if (hits.size() == 0) begin
               queue_ack(RSP_OK);
            end else begin
               foreach (hits[k])
                  queue_answer('{RSP_OK, 1'b1, hits[k], k == hits.size() - 1});
            end
         end
         default: queue_ack(RSP_OK);
      endcase
   endfunction

   task automatic note_mismatch(input string what, input logic [ID_W-1:0] want,
                                input logic [ID_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0d: %s expected %h got %h", cycle_count, what, want, got);
   endtask

   always @(posedge clock) begin
      sock_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            note_mismatch("unexpected answer, match_id", '0, rsp_match_id);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", 16'(want.status), 16'(rsp_status));
            if (rsp_match_valid !== want.hit)
               note_mismatch("match_valid", 16'(want.hit), 16'(rsp_match_valid));
            if (rsp_match_id !== want.hit_id)
               note_mismatch("match_id", want.hit_id, rsp_match_id);
            if (rsp_last !== want.last)
               note_mismatch("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   function automatic sock_cmd_type make_cmd(input logic [1:0] cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic [SAP_W-1:0] lsap,
                                             input logic [SAP_W-1:0] rsap, input logic tag,
                                             input logic [FSAP_W-1:0] dsap,
                                             input logic [FSAP_W-1:0] ssap);
      return '{cmd, id, lsap, rsap, tag, dsap, ssap};
   endfunction

   task automatic send_item(input sock_cmd_type c);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c.cmd;
      req_socket_id   <= c.id;
      req_local_sap   <= c.lsap;
      req_remote_sap  <= c.rsap;
      req_tag_present <= c.tag;
      req_frame_dsap  <= c.dsap;
      req_frame_ssap  <= c.ssap;
      do @(posedge clock); while (req_stall);
      predict_table_op(c);
   endtask

   task automatic wait_all_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_commands();
      idle_pct  = 0;
      stall_pct = 0;
      send_item(make_cmd(CMD_CREATE, 16'h0000, SAP_ANY, SAP_ANY, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_CREATE, 16'h0000, 9'd4, 9'd4, 1'b1, 8'hFF, 8'hFF));
      send_item(make_cmd(CMD_CREATE, 16'hFFFF, 9'd255, 9'd0, 1'b0, 8'h00, 8'h00));
      // negative codes other than any never match a frame
      send_item(make_cmd(CMD_CREATE, 16'h5A5A, 9'h100, 9'h1FE, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_DELETE, 16'h1234, 9'h000, 9'h000, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_NONE, 16'hFFFF, 9'h1FF, 9'h1FF, 1'b1, 8'hFF, 8'hFF));
      send_item(make_cmd(CMD_LOOKUP, 16'h0000, 9'h000, 9'h000, 1'b1, 8'h00, 8'hFE));
      send_item(make_cmd(CMD_DELETE, 16'h5A5A, 9'h000, 9'h000, 1'b0, 8'h00, 8'h00));
      wait_all_answers();
   endtask

   task automatic test_lookup_wildcards();
      stall_pct = 30;
      send_item(make_cmd(CMD_CREATE, 16'd7, 9'd0, SAP_ANY, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_CREATE, 16'd3, SAP_ANY, 9'd255, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b0, 8'h00, 8'hFF));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b1, 8'hFF, 8'h00));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b1, 8'h00, 8'hFF));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b1, 8'h01, 8'h01));
      send_item(make_cmd(CMD_DELETE, 16'd0, 9'h000, 9'h000, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b1, 8'h01, 8'h01));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b1, 8'h00, 8'hFF));
      wait_all_answers();
   endtask

   task automatic test_table_full();
      stall_pct = 0;
      for (int i = 8; i <= 20; i++)
         send_item(make_cmd(CMD_CREATE, 16'(i), SAP_ANY, SAP_ANY, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_CREATE, 16'd21, SAP_ANY, SAP_ANY, 1'b0, 8'h00, 8'h00));
      // a duplicate wins over a full table
      send_item(make_cmd(CMD_CREATE, 16'd7, SAP_ANY, SAP_ANY, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_DELETE, 16'hFFFF, 9'h000, 9'h000, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_CREATE, 16'd21, SAP_ANY, SAP_ANY, 1'b0, 8'h00, 8'h00));
      send_item(make_cmd(CMD_LOOKUP, 16'd0, 9'h000, 9'h000, 1'b1, 8'h00, 8'hFF));
      send_item(make_cmd(CMD_DELETE, 16'd21, 9'h000, 9'h000, 1'b0, 8'h00, 8'h00));
      wait_all_answers();
   endtask

   function automatic logic [SAP_W-1:0] pick_sap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return SAP_ANY;
      if (r < 70) return SAP_W'($urandom_range(0, 3));
      return SAP_W'($urandom());
   endfunction

   function automatic logic [FSAP_W-1:0] pick_frame_sap();
      if ($urandom_range(0, 99) < 70) return FSAP_W'($urandom_range(0, 3));
      return FSAP_W'($urandom());
   endfunction

   function automatic sock_cmd_type random_sock_cmd();
      sock_cmd_type c;
      int unsigned  r;
      r = $urandom_range(0, 99);
      if (r < 35)      c.cmd = CMD_CREATE;
      else if (r < 60) c.cmd = CMD_DELETE;
      else if (r < 95) c.cmd = CMD_LOOKUP;
      else             c.cmd = CMD_NONE;
      // mostly a small id pool so duplicates, deletes and full tables happen
      c.id   = ($urandom_range(0, 99) < 85) ? ID_W'($urandom_range(0, 23)) : ID_W'($urandom());
      c.lsap = pick_sap();
      c.rsap = pick_sap();
      c.tag  = $urandom_range(0, 99) < 90;
      c.dsap = pick_frame_sap();
      c.ssap = pick_frame_sap();
      return c;
   endfunction

   task automatic test_random_traffic(input int idle, input int stall, input int count);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_item(random_sock_cmd());
      // hold the sender until the table has answered everything
      wait_all_answers();
   endtask

   initial begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_commands();
      test_lookup_wildcards();
      test_table_full();
      test_random_traffic(0, 0, 61);
      test_random_traffic(51, 0, 61);
      test_random_traffic(0, 51, 61);
      test_random_traffic(37, 37, 61);
      stall_pct = 0;
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
src/swst_pkg.sv
src/swst_front.sv
src/swst_back.sv
src/sap_wildcard_socket_table_core.sv
tb/tb_sap_wildcard_socket_table_core.sv
